@@ hdl/lrd_pkg.sv @@
// shared types, constants and phase codes for the layout record decoder
package lrd_pkg;

  localparam int unsigned MAX_DIM   = 4096;
  localparam int unsigned MAX_PANES = 16;
  localparam int unsigned TITLE_MAX = 64;

  localparam logic [1:0] KIND_HDR    = 2'd0;
  localparam logic [1:0] KIND_PANE   = 2'd1;
  localparam logic [1:0] KIND_TITLE  = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;
  localparam logic [1:0] ST_PROTO = 2'd2;

  typedef enum logic [12:0] {
    PH_ROWS  = 13'b0000000000001,
    PH_COLS  = 13'b0000000000010,
    PH_GEN   = 13'b0000000000100,
    PH_COUNT = 13'b0000000001000,
    PH_ID    = 13'b0000000010000,
    PH_X     = 13'b0000000100000,
    PH_Y     = 13'b0000001000000,
    PH_PROWS = 13'b0000010000000,
    PH_PCOLS = 13'b0000100000000,
    PH_FOCUS = 13'b0001000000000,
    PH_TLEN  = 13'b0010000000000,
    PH_TITLE = 13'b0100000000000,
    PH_DONE  = 13'b1000000000000
  } phase_t;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       end_of_msg;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [31:0] tag;
    logic [12:0] height;
    logic [12:0] width;
    logic [11:0] col_pos;
    logic [11:0] row_pos;
    logic        focused;
    logic [7:0]  count_or_byte;
    logic        last_out;
  } out_item_t;

  // up to three results per byte, packed into one queue entry
  typedef struct packed {
    logic [1:0] n;
    out_item_t  r0;
    out_item_t  r1;
    out_item_t  r2;
  } bundle_t;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = 2;

  function automatic out_item_t status_item(input logic [1:0] st);
    out_item_t o;
    o = '0;
    o.kind = KIND_STATUS;
    o.status = st;
    return o;
  endfunction

endpackage

@@ hdl/lrd_front.sv @@
// front part: varint assembly, field checks and record formation, one byte a cycle unless b_full
module lrd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lrd_pkg::in_item_t in_data,
  output logic              b_valid,
  input  logic              b_full,
  output lrd_pkg::bundle_t  b_data
);
  import lrd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [63:0] accum_r, accum_nxt;
  logic [6:0]  shift_r, shift_nxt;
  logic [12:0] srows_r, srows_nxt, scols_r, scols_nxt;
  logic [4:0]  pleft_r, pleft_nxt;
  logic [63:0] tag_r, tag_nxt;
  logic [11:0] px_r, px_nxt, py_r, py_nxt;
  logic [12:0] prows_r, prows_nxt, pcols_r, pcols_nxt;
  logic        foc_r, foc_nxt;
  logic [5:0]  tlen_r, tlen_nxt;
  logic [5:0]  tleft_r, tleft_nxt;
  logic        perr_r, perr_nxt, disc_r, disc_nxt;

  logic        acc;
  logic [7:0]  b;
  logic [63:0] v;
  logic        vbig;
  logic [1:0]  err;
  logic        fin;
  out_item_t   res [3];
  logic [1:0]  n;

  assign in_stall = b_full;
  assign acc = in_valid & ~b_full;
  assign b = in_data.msg_byte;

  always_comb begin
    phase_nxt = phase_r; accum_nxt = accum_r; shift_nxt = shift_r;
    srows_nxt = srows_r; scols_nxt = scols_r; pleft_nxt = pleft_r;
    tag_nxt = tag_r; px_nxt = px_r; py_nxt = py_r;
    prows_nxt = prows_r; pcols_nxt = pcols_r; foc_nxt = foc_r;
    tlen_nxt = tlen_r; tleft_nxt = tleft_r; perr_nxt = perr_r; disc_nxt = disc_r;
    err = ST_OK; fin = 1'b0; n = 2'd0;
    res[0] = '0; res[1] = '0; res[2] = '0;
    v = accum_r | ({57'd0, b[6:0]} << shift_r);
    vbig = 1'b0;

    if (disc_r) begin
      if (in_data.end_of_msg) disc_nxt = 1'b0;
    end else begin
      unique case (phase_r)
        PH_DONE: err = ST_PROTO;
        PH_FOCUS: begin
          foc_nxt = (b != 8'd0);
          phase_nxt = PH_TLEN;
        end
        PH_TITLE: begin
          if (!perr_r) begin
            res[n].kind = KIND_TITLE;
            res[n].count_or_byte = b;
            n = n + 2'd1;
          end
          tleft_nxt = tleft_r - 6'd1;
          if (tleft_r == 6'd1) fin = 1'b1;
        end
        default: begin
          if (shift_r > 7'd63) begin
            err = ST_PROTO;
          end else if (b[7]) begin
            accum_nxt = v;
            shift_nxt = shift_r + 7'd7;
          end else begin
            accum_nxt = '0;
            shift_nxt = '0;
            vbig = |v[63:13];
            unique case (phase_r)
              PH_ROWS: begin
                if (vbig || v[12:0] > 13'(MAX_DIM)) err = ST_PROTO;
                else begin srows_nxt = v[12:0]; phase_nxt = PH_COLS; end
              end
              PH_COLS: begin
                if (vbig || v[12:0] > 13'(MAX_DIM)) err = ST_PROTO;
                else begin scols_nxt = v[12:0]; phase_nxt = PH_GEN; end
              end
              PH_GEN: begin
                tag_nxt = v;
                phase_nxt = PH_COUNT;
              end
              PH_COUNT: begin
                if (vbig || v[12:0] > 13'(MAX_PANES) || srows_r == 13'd0
                    || scols_r == 13'd0) begin
                  err = ST_PROTO;
                end else begin
                  res[n].kind = KIND_HDR;
                  res[n].tag = tag_r[31:0];
                  res[n].height = srows_r;
                  res[n].width = scols_r;
                  res[n].count_or_byte = v[7:0];
                  n = n + 2'd1;
                  pleft_nxt = v[4:0];
                  phase_nxt = (v[4:0] != 5'd0) ? PH_ID : PH_DONE;
                end
              end
              PH_ID: begin
                tag_nxt = v; px_nxt = '0; py_nxt = '0;
                prows_nxt = '0; pcols_nxt = '0; foc_nxt = 1'b0; tlen_nxt = '0;
                perr_nxt = 1'b0;
                phase_nxt = PH_X;
              end
              PH_X: begin
                if (vbig || {1'b0, v[12:0]} > {1'b0, scols_r} - 14'd1) err = ST_PROTO;
                else begin px_nxt = v[11:0]; phase_nxt = PH_Y; end
              end
              PH_Y: begin
                if (vbig || {1'b0, v[12:0]} > {1'b0, srows_r} - 14'd1) err = ST_PROTO;
                else begin py_nxt = v[11:0]; phase_nxt = PH_PROWS; end
              end
              PH_PROWS: begin
                if (vbig || v[12:0] > srows_r) err = ST_PROTO;
                else begin prows_nxt = v[12:0]; phase_nxt = PH_PCOLS; end
              end
              PH_PCOLS: begin
                if (vbig || v[12:0] > scols_r) err = ST_PROTO;
                else begin
                  pcols_nxt = v[12:0];
                  // misfit or empty pane, reported once the title is in
                  if ({2'b0, px_r} + {1'b0, v[12:0]} > {1'b0, scols_r}
                      || {2'b0, py_r} + {1'b0, prows_r} > {1'b0, srows_r}
                      || prows_r == 13'd0 || v[12:0] == 13'd0)
                    perr_nxt = 1'b1;
                  phase_nxt = PH_FOCUS;
                end
              end
              default: begin
                if (vbig || v[12:0] > 13'(TITLE_MAX - 1)) err = ST_PROTO;
                else begin
                  tlen_nxt = v[5:0];
                  if (v[5:0] == 6'd0) fin = 1'b1;
                  else begin tleft_nxt = v[5:0]; phase_nxt = PH_TITLE; end
                end
              end
            endcase
          end
        end
      endcase

      if (fin) begin
        if (perr_r || perr_nxt) err = ST_PROTO;
        else begin
          res[n].kind = KIND_PANE;
          res[n].tag = tag_r[31:0];
          res[n].height = prows_r;
          res[n].width = pcols_r;
          res[n].col_pos = px_r;
          res[n].row_pos = py_r;
          res[n].focused = foc_r;
          res[n].count_or_byte = {2'b0, tlen_nxt};
          n = n + 2'd1;
          pleft_nxt = pleft_r - 5'd1;
          phase_nxt = (pleft_r != 5'd1) ? PH_ID : PH_DONE;
        end
      end

      if (err != ST_OK) begin
        res[n] = status_item(err);
        n = n + 2'd1;
        disc_nxt = ~in_data.end_of_msg;
      end else if (in_data.end_of_msg) begin
        res[n] = status_item((phase_nxt == PH_DONE) ? ST_OK : ST_TRUNC);
        n = n + 2'd1;
      end
      if (n != 2'd0) res[n - 2'd1].last_out = 1'b1;
    end

    // every message end starts the next message from scratch
    if (in_data.end_of_msg) begin
      phase_nxt = PH_ROWS; accum_nxt = '0; shift_nxt = '0;
      srows_nxt = '0; scols_nxt = '0; pleft_nxt = '0; tag_nxt = '0;
      px_nxt = '0; py_nxt = '0; prows_nxt = '0; pcols_nxt = '0;
      foc_nxt = 1'b0; tlen_nxt = '0; tleft_nxt = '0; perr_nxt = 1'b0;
    end
  end

  assign b_valid = acc && (n != 2'd0);
  always_comb begin
    b_data.n = n;
    b_data.r0 = res[0];
    b_data.r1 = res[1];
    b_data.r2 = res[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ROWS; accum_r <= '0; shift_r <= '0;
      srows_r <= '0; scols_r <= '0; pleft_r <= '0; tag_r <= '0;
      px_r <= '0; py_r <= '0; prows_r <= '0; pcols_r <= '0;
      foc_r <= 1'b0; tlen_r <= '0; tleft_r <= '0; perr_r <= 1'b0; disc_r <= 1'b0;
    end else if (acc) begin
      phase_r <= phase_nxt; accum_r <= accum_nxt; shift_r <= shift_nxt;
      srows_r <= srows_nxt; scols_r <= scols_nxt; pleft_r <= pleft_nxt;
      tag_r <= tag_nxt; px_r <= px_nxt; py_r <= py_nxt;
      prows_r <= prows_nxt; pcols_r <= pcols_nxt; foc_r <= foc_nxt;
      tlen_r <= tlen_nxt; tleft_r <= tleft_nxt; perr_r <= perr_nxt; disc_r <= disc_nxt;
    end
  end

endmodule

@@ hdl/lrd_back.sv @@
// back part: bundle queue and result serializer driving the outputs
module lrd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               b_valid,
  output logic               b_full,
  input  lrd_pkg::bundle_t   b_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lrd_pkg::out_item_t out_data
);
  import lrd_pkg::*;

  bundle_t        q_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic [1:0]     idx_r, idx_nxt;
  bundle_t        head;
  logic           pop, push, take;

  assign head = q_r[rp_r];
  assign out_valid = (cnt_r != '0);
  always_comb begin
    case (idx_r)
      2'd0:    out_data = head.r0;
      2'd1:    out_data = head.r1;
      default: out_data = head.r2;
    endcase
  end

  assign take = out_valid & ~out_stall;
  assign pop = take && (idx_r + 2'd1 == head.n);
  assign b_full = (cnt_r == (QAW+1)'(QDEPTH));
  assign push = b_valid & ~b_full;
  assign cnt_nxt = cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
  assign idx_nxt = pop ? 2'd0 : (take ? idx_r + 2'd1 : idx_r);

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= b_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0; idx_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

endmodule

@@ hdl/layout_record_decoder_unit.sv @@
// Layout record decoder: takes one message byte per cycle (LEB128 varint fields)
// and emits header, pane, title-byte and status records. A byte is taken every
// cycle while the four-entry result queue has room; each byte yields up to three
// results, which leave at one per cycle while the output is not stalled, so a byte
// that yields several holds its queue entry until all have left. The results of an
// accepted byte are written into the result queue and presented from its head.
module layout_record_decoder_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lrd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lrd_pkg::out_item_t out_data
);
  import lrd_pkg::*;

  logic    b_valid, b_full;
  bundle_t b_data;

  lrd_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .b_valid, .b_full, .b_data
  );

  lrd_back u_back (
    .clk, .rst_n, .b_valid, .b_full, .b_data,
    .out_valid, .out_stall, .out_data
  );

  // a stalled result request must not vanish
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // front stalls exactly when the queue is full
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == b_full)
    else $error("input stall mismatch");

  // status items always carry last_out
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_STATUS |-> out_data.last_out)
    else $error("status without last_out");

endmodule
